// File: rtl/nmea_gga_position_extractor_defines.svh
// Assertion macros for the GGA position extractor.
// Included by the top level; no other dependencies.
`ifndef NMEA_GGA_POSITION_EXTRACTOR_DEFINES_SVH
`define NMEA_GGA_POSITION_EXTRACTOR_DEFINES_SVH

// same-cycle implication
`define NGPE_ASSERT_IMP(name, clk, rst_n, ante, cons, msg) \
  name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication
`define NGPE_ASSERT_NXT(name, clk, rst_n, ante, cons, msg) \
  name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// File: rtl/ngpe_pkg.sv
// Shared constants and types of the GGA position extractor.
// No dependencies.
package ngpe_pkg;

  localparam int CHAR_W      = 8;
  localparam int FIELD_DEPTH = 16;
  localparam int SCAN_SPAN   = 10;
  localparam int EMIT_LENGTH = 8;
  localparam int POS_OUT_W   = 3;

  localparam int SCAN_END  = (SCAN_SPAN < FIELD_DEPTH) ? SCAN_SPAN : FIELD_DEPTH;
  localparam int ADDR_W    = $clog2(FIELD_DEPTH);
  localparam int MEM_AW    = ADDR_W + 1;
  localparam int MEM_DEPTH = 2 * (1 << ADDR_W);
  localparam int POS_W     = $clog2(FIELD_DEPTH + 1);
  localparam int IDX_W     = $clog2((FIELD_DEPTH > EMIT_LENGTH) ? FIELD_DEPTH : EMIT_LENGTH);

  localparam logic [CHAR_W-1:0] CH_DOLLAR = 8'h24;
  localparam logic [CHAR_W-1:0] CH_G      = 8'h47;
  localparam logic [CHAR_W-1:0] CH_P      = 8'h50;
  localparam logic [CHAR_W-1:0] CH_A      = 8'h41;
  localparam logic [CHAR_W-1:0] CH_COMMA  = 8'h2C;
  localparam logic [CHAR_W-1:0] CH_DOT    = 8'h2E;

  localparam logic KIND_LON = 1'b0;
  localparam logic KIND_LAT = 1'b1;

  typedef struct packed {
    logic              wr_en;
    logic [MEM_AW-1:0] wr_addr;
    logic [CHAR_W-1:0] wr_data;
    logic              rd_en;
    logic [MEM_AW-1:0] rd_addr;
  } mem_req_t;

endpackage

// File: rtl/ngpe_in_if.sv
// Character input channel: valid/ready plus one received byte.
// Depends on ngpe_pkg.
interface ngpe_in_if;
  logic                        valid;
  logic                        ready;
  logic [ngpe_pkg::CHAR_W-1:0] rx_char;

  modport source (output valid, output rx_char, input ready);
  modport sink   (input valid, input rx_char, output ready);
endinterface

// File: rtl/ngpe_out_if.sv
// Coordinate character output channel: valid/ready plus result fields.
// Depends on ngpe_pkg.
interface ngpe_out_if;
  logic                           valid;
  logic                           ready;
  logic [ngpe_pkg::CHAR_W-1:0]    out_char;
  logic                           coordinate_kind;
  logic [ngpe_pkg::POS_OUT_W-1:0] char_position;
  logic                           last_of_run;

  modport source (output valid, output out_char, output coordinate_kind,
                  output char_position, output last_of_run, input ready);
  modport sink   (input valid, input out_char, input coordinate_kind,
                  input char_position, input last_of_run, output ready);
endinterface

// File: rtl/ngpe_store.sv
// Coordinate store: latitude and longitude buffers in one single-port memory.
// Per-entry valid bits make unwritten entries read as zero. Depends on ngpe_pkg.
module ngpe_store (
  input  logic                        clk,
  input  logic                        rst_n,
  input  ngpe_pkg::mem_req_t          req,
  output logic [ngpe_pkg::CHAR_W-1:0] rd_data
);

  logic [ngpe_pkg::CHAR_W-1:0] mem_r [ngpe_pkg::MEM_DEPTH];
  logic [ngpe_pkg::MEM_DEPTH-1:0] valid_r;
  logic [ngpe_pkg::CHAR_W-1:0] rd_data_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= '0;
    end else if (req.wr_en) begin
      valid_r[req.wr_addr] <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (req.wr_en) begin
      mem_r[req.wr_addr] <= req.wr_data;
    end
    if (req.rd_en) begin
      rd_data_r <= valid_r[req.rd_addr] ? mem_r[req.rd_addr] : '0;
    end
  end

  assign rd_data = rd_data_r;

endmodule

// File: rtl/ngpe_ctrl.sv
// Sentence parser and repair/emit sequencer of the GGA position extractor.
// Drives the coordinate store; depends on ngpe_pkg, ngpe_in_if, ngpe_out_if.
module ngpe_ctrl (
  input  logic                        clk,
  input  logic                        rst_n,
  ngpe_in_if.sink                     in_ch,
  ngpe_out_if.source                  out_ch,
  output ngpe_pkg::mem_req_t          mem_req,
  input  logic [ngpe_pkg::CHAR_W-1:0] mem_rd_data
);

  localparam int IDX_W  = ngpe_pkg::IDX_W;
  localparam int POS_W  = ngpe_pkg::POS_W;
  localparam int ADDR_W = ngpe_pkg::ADDR_W;

  typedef enum logic [4:0] {
    S_DOLLAR, S_G1, S_P, S_G2, S_G3, S_A, S_COMMA, S_TIME,
    S_LAT, S_LAT_DIR, S_GAP, S_LON, S_LON_DIR,
    S_R_RD, S_R_CHK, S_R_SW, S_R_WR2,
    S_E_RD, S_E_LD, S_E_WAIT
  } state_t;

  state_t                         state_r, state_nxt;
  logic [POS_W-1:0]               pos_r, pos_nxt;
  logic                           kind_r, kind_nxt;
  logic [IDX_W-1:0]               idx_r, idx_nxt;
  logic                           out_valid_r, out_valid_nxt;
  logic [ngpe_pkg::CHAR_W-1:0]    out_char_r, out_char_nxt;
  logic                           out_kind_r, out_kind_nxt;
  logic [ngpe_pkg::POS_OUT_W-1:0] out_pos_r, out_pos_nxt;
  logic                           out_last_r, out_last_nxt;

  logic                        in_rdy;
  logic                        acc;
  logic [ngpe_pkg::CHAR_W-1:0] c;
  logic                        pos_room;
  logic                        idx_past;
  logic                        scan_last;
  logic                        emit_last;
  logic [IDX_W-1:0]            idx_m2;

  assign c         = in_ch.rx_char;
  assign acc       = in_ch.valid && in_rdy;
  assign pos_room  = pos_r < POS_W'(ngpe_pkg::FIELD_DEPTH);
  assign idx_past  = {1'b0, idx_r} >= (IDX_W + 1)'(ngpe_pkg::FIELD_DEPTH);
  assign scan_last = idx_r == IDX_W'(ngpe_pkg::SCAN_END - 1);
  assign emit_last = idx_r == IDX_W'(ngpe_pkg::EMIT_LENGTH - 1);
  assign idx_m2    = idx_r - IDX_W'(2);

  always_comb begin
    state_nxt     = state_r;
    pos_nxt       = pos_r;
    kind_nxt      = kind_r;
    idx_nxt       = idx_r;
    out_valid_nxt = out_valid_r;
    out_char_nxt  = out_char_r;
    out_kind_nxt  = out_kind_r;
    out_pos_nxt   = out_pos_r;
    out_last_nxt  = out_last_r;
    mem_req       = '0;
    in_rdy        = 1'b0;

    unique case (state_r)
      S_DOLLAR: begin
        in_rdy = 1'b1;
        if (acc && c == ngpe_pkg::CH_DOLLAR) state_nxt = S_G1;
      end
      S_G1: begin
        in_rdy = 1'b1;
        if (acc) state_nxt = (c == ngpe_pkg::CH_G) ? S_P : S_DOLLAR;
      end
      S_P: begin
        in_rdy = 1'b1;
        if (acc) state_nxt = (c == ngpe_pkg::CH_P) ? S_G2 : S_DOLLAR;
      end
      S_G2: begin
        in_rdy = 1'b1;
        if (acc) state_nxt = (c == ngpe_pkg::CH_G) ? S_G3 : S_DOLLAR;
      end
      S_G3: begin
        in_rdy = 1'b1;
        if (acc) state_nxt = (c == ngpe_pkg::CH_G) ? S_A : S_DOLLAR;
      end
      S_A: begin
        in_rdy = 1'b1;
        if (acc) state_nxt = (c == ngpe_pkg::CH_A) ? S_COMMA : S_DOLLAR;
      end
      S_COMMA: begin
        in_rdy = 1'b1;
        if (acc) state_nxt = (c == ngpe_pkg::CH_COMMA) ? S_TIME : S_DOLLAR;
      end
      S_TIME: begin
        in_rdy = 1'b1;
        if (acc && c == ngpe_pkg::CH_COMMA) begin
          state_nxt = S_LAT;
          pos_nxt   = '0;
        end
      end
      S_LAT, S_LON: begin
        in_rdy = 1'b1;
        if (acc) begin
          if (pos_room) begin
            mem_req.wr_en   = 1'b1;
            mem_req.wr_addr = {(state_r == S_LAT) ? ngpe_pkg::KIND_LAT : ngpe_pkg::KIND_LON,
                               pos_r[ADDR_W-1:0]};
            mem_req.wr_data = c;
            pos_nxt         = pos_r + POS_W'(1);
          end
          if (c == ngpe_pkg::CH_COMMA) state_nxt = (state_r == S_LAT) ? S_LAT_DIR : S_LON_DIR;
        end
      end
      S_LAT_DIR: begin
        in_rdy = 1'b1;
        if (acc) state_nxt = S_GAP;
      end
      S_GAP: begin
        in_rdy = 1'b1;
        if (acc) begin
          state_nxt = S_LON;
          pos_nxt   = '0;
        end
      end
      S_LON_DIR: begin
        in_rdy = 1'b1;
        if (acc) begin
          state_nxt = S_R_RD;
          kind_nxt  = ngpe_pkg::KIND_LAT;
          idx_nxt   = IDX_W'(2);
        end
      end
      S_R_RD: begin
        mem_req.rd_en   = 1'b1;
        mem_req.rd_addr = {kind_r, idx_r[ADDR_W-1:0]};
        state_nxt       = S_R_CHK;
      end
      S_R_CHK, S_R_WR2: begin
        if (state_r == S_R_CHK && mem_rd_data == ngpe_pkg::CH_DOT) begin
          // dot found: fetch the character two places back for the swap
          mem_req.rd_en   = 1'b1;
          mem_req.rd_addr = {kind_r, idx_m2[ADDR_W-1:0]};
          state_nxt       = S_R_SW;
        end else begin
          if (state_r == S_R_WR2) begin
            mem_req.wr_en   = 1'b1;
            mem_req.wr_addr = {kind_r, idx_m2[ADDR_W-1:0]};
            mem_req.wr_data = ngpe_pkg::CH_DOT;
          end
          if (!scan_last) begin
            idx_nxt   = idx_r + IDX_W'(1);
            state_nxt = S_R_RD;
          end else if (kind_r == ngpe_pkg::KIND_LAT) begin
            kind_nxt  = ngpe_pkg::KIND_LON;
            idx_nxt   = IDX_W'(2);
            state_nxt = S_R_RD;
          end else begin
            kind_nxt  = ngpe_pkg::KIND_LON;
            idx_nxt   = '0;
            state_nxt = S_E_RD;
          end
        end
      end
      S_R_SW: begin
        mem_req.wr_en   = 1'b1;
        mem_req.wr_addr = {kind_r, idx_r[ADDR_W-1:0]};
        mem_req.wr_data = mem_rd_data;
        state_nxt       = S_R_WR2;
      end
      S_E_RD: begin
        mem_req.rd_en   = 1'b1;
        mem_req.rd_addr = {kind_r, idx_r[ADDR_W-1:0]};
        state_nxt       = S_E_LD;
      end
      S_E_LD: begin
        out_char_nxt  = idx_past ? '0 : mem_rd_data;
        out_kind_nxt  = kind_r;
        out_pos_nxt   = idx_r[ngpe_pkg::POS_OUT_W-1:0];
        out_last_nxt  = (kind_r == ngpe_pkg::KIND_LAT) && emit_last;
        out_valid_nxt = 1'b1;
        state_nxt     = S_E_WAIT;
      end
      S_E_WAIT: begin
        if (out_ch.ready) begin
          out_valid_nxt = 1'b0;
          if (!emit_last) begin
            idx_nxt   = idx_r + IDX_W'(1);
            state_nxt = S_E_RD;
          end else if (kind_r == ngpe_pkg::KIND_LON) begin
            kind_nxt  = ngpe_pkg::KIND_LAT;
            idx_nxt   = '0;
            state_nxt = S_E_RD;
          end else begin
            state_nxt = S_DOLLAR;
          end
        end
      end
      default: state_nxt = S_DOLLAR;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_DOLLAR;
      pos_r       <= '0;
      kind_r      <= ngpe_pkg::KIND_LON;
      idx_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      pos_r       <= pos_nxt;
      kind_r      <= kind_nxt;
      idx_r       <= idx_nxt;
      out_valid_r <= out_valid_nxt;
    end
    out_char_r <= out_char_nxt;
    out_kind_r <= out_kind_nxt;
    out_pos_r  <= out_pos_nxt;
    out_last_r <= out_last_nxt;
  end

  assign in_ch.ready            = in_rdy;
  assign out_ch.valid           = out_valid_r;
  assign out_ch.out_char        = out_char_r;
  assign out_ch.coordinate_kind = out_kind_r;
  assign out_ch.char_position   = out_pos_r;
  assign out_ch.last_of_run     = out_last_r;

endmodule

// File: rtl/nmea_gga_position_extractor.sv
// Top level of the GGA position extractor: parser/sequencer plus coordinate store.
// Depends on ngpe_pkg, ngpe_in_if, ngpe_out_if, ngpe_store, ngpe_ctrl and the defines header.
//
// Usage:
//   in_ch takes one sentence character per item. While a sentence is being parsed
//   the block is ready every cycle.
//   After "$GPGGA," the time field is skipped, latitude and longitude characters
//   (with their closing commas) go into the store, and on the longitude direction
//   character the block drops ready and works alone:
//   - repair: each store is scanned from index 2 to SCAN_END-1 through the single
//     store port, one read per position plus a read and two writes for each '.'
//     swapped with the character two places back, both stores in turn;
//   - emit: 2*EMIT_LENGTH items on out_ch, longitude first, then latitude, each
//     through a store read, an output load and a handoff that waits on the receiver.
//   A stalled receiver simply holds the output register; nothing is lost.
//   After the last item is taken the block is ready again on the next cycle.
//   Reset (synchronous, rst_n low) returns to waiting for '$' and clears the
//   store valid bits so both coordinates read as zeros until written.
`include "nmea_gga_position_extractor_defines.svh"

module nmea_gga_position_extractor (
  input  logic       clk,
  input  logic       rst_n,
  ngpe_in_if.sink    in_ch,
  ngpe_out_if.source out_ch
);

  ngpe_pkg::mem_req_t          mem_req;
  logic [ngpe_pkg::CHAR_W-1:0] mem_rd_data;

  ngpe_ctrl u_ctrl (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_ch       (in_ch),
    .out_ch      (out_ch),
    .mem_req     (mem_req),
    .mem_rd_data (mem_rd_data)
  );

  ngpe_store u_store (
    .clk     (clk),
    .rst_n   (rst_n),
    .req     (mem_req),
    .rd_data (mem_rd_data)
  );

  `NGPE_ASSERT_IMP(a_no_input_while_emitting, clk, rst_n, out_ch.valid, !in_ch.ready, "input ready during emit")
  `NGPE_ASSERT_IMP(a_last_is_final_latitude, clk, rst_n, out_ch.valid && out_ch.last_of_run, (out_ch.coordinate_kind == ngpe_pkg::KIND_LAT) && (out_ch.char_position == 3'((ngpe_pkg::EMIT_LENGTH - 1) % 8)), "last flag on wrong item")
  `NGPE_ASSERT_NXT(a_ready_after_last, clk, rst_n, out_ch.valid && out_ch.ready && out_ch.last_of_run, in_ch.ready && !out_ch.valid, "not back to parsing after run")

endmodule

// File: dv/ngpe_coord_checker.sv
// Scoreboard for the GGA position extractor: tracks the sentence parser state and
// both coordinate stores, predicts every output item and compares it in order.
// Depends on ngpe_pkg, ngpe_in_if and ngpe_out_if.
module ngpe_coord_checker
  import ngpe_pkg::*;
(
  input  logic clk,
  input  logic rst_n,
  ngpe_in_if   in_ch,
  ngpe_out_if  out_ch,
  output int   err_count,
  output int   pending
);
  timeunit 1ns;
  timeprecision 1ps;

  typedef enum logic [3:0] {
    WAIT_DOLLAR, HDR_G1, HDR_P, HDR_G2, HDR_G3, HDR_A, HDR_COMMA,
    SKIP_TIME, LAT_FIELD, LAT_DIR, FIELD_GAP, LON_FIELD, LON_DIR
  } gga_phase_t;

  typedef struct packed {
    logic [CHAR_W-1:0]    ch;
    logic                 kind;
    logic [POS_OUT_W-1:0] pos;
    logic                 last;
  } coord_char_t;

  gga_phase_t        phase;
  logic [CHAR_W-1:0] coord_store [2][FIELD_DEPTH];
  int                wr_pos;
  coord_char_t       coord_q [$];

  task automatic put_char(input int k, input logic [CHAR_W-1:0] c);
    if (wr_pos < FIELD_DEPTH) begin
      coord_store[k][wr_pos] = c;
      wr_pos++;
    end
  endtask

  // a '.' at index 2 to SCAN_END-1 trades places with the char two before it
  task automatic fix_dots(input int k);
    logic [CHAR_W-1:0] t;
    for (int i = 2; i < SCAN_SPAN && i < FIELD_DEPTH; i++) begin
      if (coord_store[k][i] == CH_DOT) begin
        t                    = coord_store[k][i];
        coord_store[k][i]    = coord_store[k][i-2];
        coord_store[k][i-2]  = t;
      end
    end
  endtask

  task automatic queue_coord(input int k);
    coord_char_t e;
    for (int i = 0; i < EMIT_LENGTH; i++) begin
      e.ch   = (i < FIELD_DEPTH) ? coord_store[k][i] : '0;
      e.kind = k[0];
      e.pos  = POS_OUT_W'(i);
      e.last = (k == int'(KIND_LAT)) && (i == EMIT_LENGTH - 1);
      coord_q.push_back(e);
    end
  endtask

  task automatic take_char(input logic [CHAR_W-1:0] c);
    case (phase)
      WAIT_DOLLAR: if (c == CH_DOLLAR) phase = HDR_G1;
      HDR_G1:      phase = (c == CH_G) ? HDR_P : WAIT_DOLLAR;
      HDR_P:       phase = (c == CH_P) ? HDR_G2 : WAIT_DOLLAR;
      HDR_G2:      phase = (c == CH_G) ? HDR_G3 : WAIT_DOLLAR;
      HDR_G3:      phase = (c == CH_G) ? HDR_A : WAIT_DOLLAR;
      HDR_A:       phase = (c == CH_A) ? HDR_COMMA : WAIT_DOLLAR;
      HDR_COMMA:   phase = (c == CH_COMMA) ? SKIP_TIME : WAIT_DOLLAR;
      SKIP_TIME: begin
        if (c == CH_COMMA) begin
          phase  = LAT_FIELD;
          wr_pos = 0;
        end
      end
      LAT_FIELD: begin
        put_char(int'(KIND_LAT), c);
        if (c == CH_COMMA) phase = LAT_DIR;
      end
      LAT_DIR:     phase = FIELD_GAP;
      FIELD_GAP: begin
        phase  = LON_FIELD;
        wr_pos = 0;
      end
      LON_FIELD: begin
        put_char(int'(KIND_LON), c);
        if (c == CH_COMMA) phase = LON_DIR;
      end
      LON_DIR: begin
        fix_dots(int'(KIND_LAT));
        fix_dots(int'(KIND_LON));
        queue_coord(int'(KIND_LON));
        queue_coord(int'(KIND_LAT));
        phase = WAIT_DOLLAR;
      end
      default:     phase = WAIT_DOLLAR;
    endcase
  endtask

  always @(posedge clk) begin
    coord_char_t got;
    coord_char_t want;
    if (!rst_n) begin
      phase  = WAIT_DOLLAR;
      wr_pos = 0;
      for (int k = 0; k < 2; k++)
        for (int i = 0; i < FIELD_DEPTH; i++) coord_store[k][i] = '0;
      coord_q.delete();
    end else begin
      // results first: an item taken this edge cannot produce one yet
      if (out_ch.valid && out_ch.ready) begin
        got.ch   = out_ch.out_char;
        got.kind = out_ch.coordinate_kind;
        got.pos  = out_ch.char_position;
        got.last = out_ch.last_of_run;
        if (coord_q.size() == 0) begin
          $display("%0t: unexpected item char=%h kind=%b pos=%0d last=%b",
                   $time, got.ch, got.kind, got.pos, got.last);
          err_count++;
        end else begin
          want = coord_q.pop_front();
          if (got !== want) begin
            $display("%0t: mismatch expected char=%h kind=%b pos=%0d last=%b",
                     $time, want.ch, want.kind, want.pos, want.last);
            $display("%0t:          actual   char=%h kind=%b pos=%0d last=%b",
                     $time, got.ch, got.kind, got.pos, got.last);
            err_count++;
          end
        end
      end
      if (in_ch.valid && in_ch.ready) take_char(in_ch.rx_char);
    end
    pending = coord_q.size();
  end

endmodule

// File: dv/nmea_gga_position_extractor_tb.sv
// Testbench top for the GGA position extractor: clock, reset, sentence stimulus
// with sender and receiver stalls, and the final verdict.
// Depends on ngpe_pkg, both channel interfaces, the block and ngpe_coord_checker.
module nmea_gga_position_extractor_tb;
  timeunit 1ns;
  timeprecision 1ps;
  import ngpe_pkg::*;

  localparam int DIRECTED_ITEMS = 23;
  localparam int TOTAL_ITEMS    = DIRECTED_ITEMS + 165;
  localparam int CYCLE_LIMIT    = 200000;
  localparam int SETTLE_CYCLES  = 100;

  logic clk   = 1'b0;
  logic rst_n = 1'b0;
  int   tx_idle_pct = 31;
  int   rx_idle_pct = 66;
  int   sent   = 0;
  int   cycles = 0;
  int   err_count;
  int   pending;
  bit   long_seen = 1'b0;

  ngpe_in_if  in_ch ();
  ngpe_out_if out_ch ();

  nmea_gga_position_extractor u_dut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch),
    .out_ch (out_ch)
  );

  ngpe_coord_checker u_chk (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_ch     (in_ch),
    .out_ch    (out_ch),
    .err_count (err_count),
    .pending   (pending)
  );

  always #5 clk = ~clk;

  always @(posedge clk) begin
    out_ch.ready <= ($urandom_range(99) >= rx_idle_pct);
  end

  always @(posedge clk) begin
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("nmea_gga_position_extractor_tb: done, errors");
      $finish;
    end
  end

  function automatic logic [CHAR_W-1:0] hdr_byte(input int i);
    case (i)
      0:       return CH_DOLLAR;
      1:       return CH_G;
      2:       return CH_P;
      3:       return CH_G;
      4:       return CH_G;
      5:       return CH_A;
      default: return CH_COMMA;
    endcase
  endfunction

  // field content: dots and digits mostly, any non-comma byte otherwise
  function automatic logic [CHAR_W-1:0] field_byte();
    logic [CHAR_W-1:0] c;
    case ($urandom_range(7))
      0, 1:       c = CH_DOT;
      2, 3, 4, 5: c = 8'h30 + CHAR_W'($urandom_range(9));
      default:    c = CHAR_W'($urandom_range(255));
    endcase
    return (c == CH_COMMA) ? CH_DOT : c;
  endfunction

  function automatic int pick_len();
    return ($urandom_range(5) == 0) ? $urandom_range(17, 22) : $urandom_range(0, 12);
  endfunction

  task automatic send_char(input logic [CHAR_W-1:0] c);
    if (sent < TOTAL_ITEMS / 3) begin
      tx_idle_pct = 31;
      rx_idle_pct = 66;
    end else if (sent < 2 * TOTAL_ITEMS / 3) begin
      tx_idle_pct = 66;
      rx_idle_pct = 31;
    end else begin
      tx_idle_pct = 0;
      rx_idle_pct = 0;
    end
    while ($urandom_range(99) < tx_idle_pct) begin
      in_ch.valid <= 1'b0;
      @(posedge clk);
    end
    in_ch.valid   <= 1'b1;
    in_ch.rx_char <= c;
    do @(posedge clk); while (!in_ch.ready);
    sent++;
  endtask

  task automatic send_header(input int n);
    for (int i = 0; i < n; i++) send_char(hdr_byte(i));
  endtask

  task automatic send_field(input int len);
    repeat (len) send_char(field_byte());
    send_char(CH_COMMA);
  endtask

  task automatic send_sentence();
    int lat_len;
    lat_len   = long_seen ? pick_len() : 20;
    long_seen = 1'b1;
    send_header(7);
    repeat ($urandom_range(0, 10)) send_char(field_byte());
    send_char(CH_COMMA);
    send_field(lat_len);
    send_char(CHAR_W'($urandom_range(255)));
    send_char(CHAR_W'($urandom_range(255)));
    send_field(pick_len());
    send_char(CHAR_W'($urandom_range(255)));
  endtask

  initial begin
    int                sel;
    int                n;
    logic [CHAR_W-1:0] w;
    in_ch.valid   <= 1'b0;
    in_ch.rx_char <= '0;
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;

    // '$' after "$G" is dropped, not taken as a new start
    send_char(CH_DOLLAR);
    send_char(CH_G);
    send_char(CH_DOLLAR);
    // empty time field, dot at index 1 stays, byte extremes in latitude
    send_header(7);
    send_char(CH_COMMA);
    send_char(8'h00);
    send_char(CH_DOT);
    send_char(8'hFF);
    send_char(CH_COMMA);
    send_char("N");
    send_char(CH_COMMA);
    // dot at index 2 moves to the front of the longitude
    send_char("1");
    send_char("2");
    send_char(CH_DOT);
    send_char("4");
    send_char(CH_COMMA);
    send_char("E");

    while (sent < TOTAL_ITEMS) begin
      sel = $urandom_range(99);
      if (sel < 75) begin
        send_sentence();
      end else if (sel < 90) begin
        n = $urandom_range(1, 6);
        send_header(n);
        do w = CHAR_W'($urandom_range(255)); while (w == hdr_byte(n));
        send_char(w);
      end else begin
        repeat ($urandom_range(1, 5)) send_char(CHAR_W'($urandom_range(255)));
      end
    end

    in_ch.valid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
    if (err_count == 0) begin
      $display("nmea_gga_position_extractor_tb: done, clean");
    end else begin
      $display("nmea_gga_position_extractor_tb: done, errors");
    end
    $finish;
  end

endmodule

// File: sim.f
+incdir+rtl
rtl/ngpe_pkg.sv
rtl/ngpe_in_if.sv
rtl/ngpe_out_if.sv
rtl/ngpe_store.sv
rtl/ngpe_ctrl.sv
rtl/nmea_gga_position_extractor.sv
dv/ngpe_coord_checker.sv
dv/nmea_gga_position_extractor_tb.sv
